[design/tsra_pkg.sv]
// Shared constants, types and codes for the transposed sparse range accumulator.
package tsra_pkg;

    // Store geometry
    localparam int NUM_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(NUM_VERTICES);

    // Field widths
    localparam int COL_W  = 10;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 2 * VAL_W;
    localparam int SUM_W  = 40;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Saturation bounds of the column sum
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Reset values of the range registers
    localparam logic [COL_W-1:0] RANGE_LOW_RESET  = '0;
    localparam logic [COL_W-1:0] RANGE_HIGH_RESET = '1;

    typedef enum logic
    {
        CMD_ACCUM = 1'b0,
        CMD_READ  = 1'b1
    } command_t;

    // Register select taken from paddr bit 2
    typedef enum logic
    {
        REG_RANGE_LOW  = 1'b0,
        REG_RANGE_HIGH = 1'b1
    } reg_index_t;

    typedef enum logic
    {
        ST_CLEAR,
        ST_RUN
    } state_t;

    // One word of the column store
    typedef struct packed
    {
        logic                    mark;
        logic signed [SUM_W-1:0] sum;
    } entry_t;

    // One result beat
    typedef struct packed
    {
        logic [COL_W-1:0]        col;
        logic signed [SUM_W-1:0] sum;
        logic                    sat;
    } result_t;

endpackage

[design/tsra_if.sv]
// Valid/ready channel interfaces for command items and read results.
interface tsra_item_if;
    import tsra_pkg::*;

    logic                    valid;
    logic                    ready;
    command_t                command;
    logic signed [VAL_W-1:0] row_value;
    logic [COL_W-1:0]        column_index;
    logic signed [VAL_W-1:0] entry_value;

    modport source (output valid, command, row_value, column_index, entry_value,
                    input ready);
    modport sink   (input valid, command, row_value, column_index, entry_value,
                    output ready);
endinterface

interface tsra_result_if;
    import tsra_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [COL_W-1:0]        result_column;
    logic signed [SUM_W-1:0] column_sum;
    logic                    saturated;

    modport source (output valid, result_column, column_sum, saturated,
                    input ready);
    modport sink   (input valid, result_column, column_sum, saturated,
                    output ready);
endinterface

[design/transposed_spmv_range_accumulate_top.sv]
// Top level: column accumulator store with multiply, saturating add and read-clear.
//
// Usage:
//   items   : valid/ready command beats. CMD_ACCUM adds row_value * entry_value
//             into the column's sum when column_index lies inside
//             [range_low, range_high]; otherwise the beat is dropped.
//             CMD_READ returns the column's sum and saturation mark and clears
//             both; it ignores the range.
//   results : one beat per CMD_READ, in command order.
//   APB     : range_low at byte address 0, range_high at byte address 4
//             (paddr bit 2 selects). Write only while the block is idle.
// Throughput: one command per cycle unless stalled. The store is a single
//   synchronous RAM, read at the accept edge and written back the next cycle; a
//   command on the column written in the previous cycle takes the forwarded word.
// Results: a read result passes the update stage, then is registered into the queue.
// Reset: a clearing pass writes zero to every store entry; items.ready stays
//   low until it ends. APB stays live.
// Stall: a two-beat output queue lets commands keep flowing while a result waits;
//   after the clear, items.ready drops only when the queue could otherwise overflow.
module transposed_spmv_range_accumulate_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    tsra_item_if.sink                       items,
    tsra_result_if.source                   results,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tsra_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tsra_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tsra_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import tsra_pkg::*;

    // Configuration
    logic [COL_W-1:0] range_low_reg;
    logic [COL_W-1:0] range_high_reg;
    logic             cfg_write;
    reg_index_t       cfg_sel;

    // Control state
    state_t            state_reg;
    state_t            state_next;
    logic [ADDR_W-1:0] clear_addr_reg;
    logic [ADDR_W-1:0] clear_addr_next;

    // Accept stage
    logic                     accept;
    logic                     in_range;
    logic                     in_store;
    logic [ADDR_W-1:0]        in_addr;
    logic signed [PROD_W-1:0] product;

    // Update stage
    logic                     s1_valid_reg;
    logic                     s1_read_reg;
    logic                     s1_in_store_reg;
    logic [COL_W-1:0]         s1_col_reg;
    logic [ADDR_W-1:0]        s1_addr_reg;
    logic signed [PROD_W-1:0] s1_prod_reg;

    // Store
    entry_t            mem [NUM_VERTICES];
    entry_t            mem_rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;

    // Write-back forwarding
    logic              wb_valid_reg;
    logic [ADDR_W-1:0] wb_addr_reg;
    entry_t            wb_data_reg;
    entry_t            base;
    logic signed [SUM_W:0] sum_ext;
    logic              overflow;
    entry_t            acc_word;

    // Output queue
    result_t    fifo0_reg;
    result_t    fifo1_reg;
    result_t    fifo0_next;
    result_t    fifo1_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] occupancy;
    logic       push;
    logic       pop;
    result_t    push_data;

    // APB decode
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = reg_index_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_sel)
            REG_RANGE_LOW:  prdata = APB_DATA_W'(range_low_reg);
            REG_RANGE_HIGH: prdata = APB_DATA_W'(range_high_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= RANGE_LOW_RESET;
            range_high_reg <= RANGE_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_RANGE_LOW:  range_low_reg  <= pwdata[COL_W-1:0];
                REG_RANGE_HIGH: range_high_reg <= pwdata[COL_W-1:0];
                default:        ;
            endcase
        end
    end

    // Sweep the store after reset, then run
    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clear_addr_next = clear_addr_reg + 1'b1;
                if (clear_addr_reg == ADDR_W'(NUM_VERTICES - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                clear_addr_next = clear_addr_reg;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    // Accept when the queue keeps room for every result in flight
    assign pop         = results.valid && results.ready;
    assign push        = s1_valid_reg && s1_read_reg;
    assign occupancy   = count_reg + 2'(push) - 2'(pop);
    assign items.ready = (state_reg == ST_RUN) && (occupancy <= 2'd1);
    assign accept      = items.valid && items.ready;

    assign in_range = (items.column_index >= range_low_reg) &&
                      (items.column_index <= range_high_reg);
    assign in_store = 32'(items.column_index) < NUM_VERTICES;
    assign in_addr  = ADDR_W'(items.column_index);
    assign product  = items.row_value * items.entry_value;

    // Advance into the update stage; drop out-of-range accumulates here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept &&
                            ((items.command == CMD_READ) || (in_range && in_store));
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_read_reg     <= (items.command == CMD_READ);
            s1_in_store_reg <= in_store;
            s1_col_reg      <= items.column_index;
            s1_addr_reg     <= in_addr;
            s1_prod_reg     <= product;
        end
    end

    // Store read and write ports
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_rdata_reg <= mem[in_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // Take the word written last cycle when it hits the same column
    assign base = (wb_valid_reg && (wb_addr_reg == s1_addr_reg)) ? wb_data_reg
                                                                 : mem_rdata_reg;

    // Saturating add of the product
    assign sum_ext  = $signed({base.sum[SUM_W-1], base.sum}) +
                      $signed({{(SUM_W + 1 - PROD_W){s1_prod_reg[PROD_W-1]}}, s1_prod_reg});
    assign overflow = sum_ext[SUM_W] != sum_ext[SUM_W-1];

    always_comb
    begin
        acc_word.mark = base.mark || overflow;
        if (!overflow)
        begin
            acc_word.sum = sum_ext[SUM_W-1:0];
        end
        else if (sum_ext[SUM_W])
        begin
            acc_word.sum = SUM_MIN;
        end
        else
        begin
            acc_word.sum = SUM_MAX;
        end
    end

    // Select the store write: clearing sweep, accumulate or read-clear
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = s1_addr_reg;
        mem_wdata = acc_word;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clear_addr_reg;
            mem_wdata = '0;
        end
        else if (s1_valid_reg && s1_in_store_reg)
        begin
            mem_we = 1'b1;
            if (s1_read_reg)
            begin
                mem_wdata = '0;
            end
        end
    end

    // Hold the last write for forwarding; writes of the clearing sweep are not forwarded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= mem_we && (state_reg == ST_RUN);
        end
    end

    always_ff @(posedge clk)
    begin
        wb_addr_reg <= mem_waddr;
        wb_data_reg <= mem_wdata;
    end

    // Read result: zero for a column beyond the store
    always_comb
    begin
        push_data.col = s1_col_reg;
        push_data.sum = s1_in_store_reg ? base.sum : '0;
        push_data.sat = s1_in_store_reg && base.mark;
    end

    // Two-beat output queue
    always_comb
    begin
        fifo0_next = fifo0_reg;
        fifo1_next = fifo1_reg;
        if (pop)
        begin
            fifo0_next = fifo1_reg;
        end
        if (push)
        begin
            if ((count_reg - 2'(pop)) == 2'd0)
            begin
                fifo0_next = push_data;
            end
            else
            begin
                fifo1_next = push_data;
            end
        end
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fifo0_reg <= fifo0_next;
        fifo1_reg <= fifo1_next;
    end

    assign results.valid         = count_reg != 2'd0;
    assign results.result_column = fifo0_reg.col;
    assign results.column_sum    = fifo0_reg.sum;
    assign results.saturated     = fifo0_reg.sat;

    // The output queue never takes a beat it has no room for
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && (count_reg == 2'd2)))
        else $error("output queue overflow");

    // A read of a stored column writes back a cleared word
    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_read_reg && s1_in_store_reg)
        |=> (wb_valid_reg && (wb_data_reg == entry_t'('0))))
        else $error("read did not clear its column");

    // No command is in flight during the clearing sweep
    a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!s1_valid_reg && !items.ready))
        else $error("command active during store clear");

endmodule
